/* hw/rtl/ascon_pkg.sv */
// Shared types and constants for the Ascon AEAD engine.
`default_nettype none
package ascon_pkg;
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_AD    = 2'd1;
   localparam logic [1:0] OP_MSG   = 2'd2;
   localparam logic [1:0] OP_FIN   = 2'd3;

   localparam logic [1:0] VAR_128  = 2'd0;
   localparam logic [1:0] VAR_128A = 2'd1;
   localparam logic [1:0] VAR_80PQ = 2'd2;

   localparam logic [63:0] IV_128   = 64'h80400c0600000000;
   localparam logic [63:0] IV_128A  = 64'h80800c0800000000;
   localparam logic [31:0] IV_80PQ  = 32'ha0400c06;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // datapath commands
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_LOAD  = 3'd1; // load IV, key, nonce
   localparam logic [2:0] CMD_ROUND = 3'd2; // one permutation round
   localparam logic [2:0] CMD_KEYIN = 3'd3; // xor key into tail after init
   localparam logic [2:0] CMD_ABS   = 3'd4; // absorb AD block
   localparam logic [2:0] CMD_MSG   = 3'd5; // message block in/out
   localparam logic [2:0] CMD_PAD0  = 3'd6; // pad byte at position 0
   localparam logic [2:0] CMD_SEP   = 3'd7; // domain separator

   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] rnd;       // round index 0..11
      logic       pad_n;     // during ABS/MSG: add pad at n
      logic       fin_key;   // during SEP-less key xor before final
      logic       capture;   // capture result
   } ctrl_type;

   function automatic logic [63:0] top_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++)
         if (i < n) m[63-8*i -: 8] = 8'hff;
      return m;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/ascon_datapath.sv */
// Ascon sponge state, one round per cycle, block absorb and tag logic.
`default_nettype none
module ascon_datapath
   import ascon_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctrl_type     ctrl,
   input  wire logic [1:0]   variant,
   input  wire logic         direction,
   input  wire logic [31:0]  key_top,
   input  wire logic [63:0]  key_high,
   input  wire logic [63:0]  key_low,
   input  wire logic [63:0]  nonce_high,
   input  wire logic [63:0]  nonce_low,
   input  wire logic [63:0]  data_high,
   input  wire logic [63:0]  data_low,
   input  wire logic [4:0]   n_bytes,
   output logic [63:0]       res_high,
   output logic [63:0]       res_low,
   output logic              res_match
);
   logic [63:0] s_ff [5];
   logic [63:0] s_in [5];
   logic [63:0] o_high_ff, o_high_in, o_low_ff, o_low_in;
   logic        match_ff, match_in;

   logic pq, wide;
   logic [63:0] m0, m1, pad0, pad1, x0, x1, t0, t1;
   logic [63:0] a [5];
   logic [63:0] b [5];
   logic [63:0] c [5];
   logic [7:0]  rc;
   logic [4:0]  nlo;

   assign pq   = (variant == VAR_80PQ);
   assign wide = (variant == VAR_128A);

   always_comb begin
      nlo  = (n_bytes > 5'd8) ? 5'd8 : n_bytes;
      m0   = top_mask(nlo[3:0]);
      m1   = wide ? top_mask(n_bytes > 5'd8 ? 4'(n_bytes - 5'd8) : 4'd0) : 64'd0;
      pad0 = '0;
      pad1 = '0;
      if (n_bytes < 5'd8)
         pad0 = {PAD_BYTE, 56'd0} >> (8 * n_bytes[2:0]);
      else
         pad1 = {PAD_BYTE, 56'd0} >> (8 * n_bytes[2:0]);
   end

   // one round
   always_comb begin
      rc = {4'hf - ctrl.rnd, ctrl.rnd};
      a[0] = s_ff[0] ^ s_ff[4];
      a[1] = s_ff[1];
      a[2] = s_ff[2] ^ {56'd0, rc} ^ s_ff[1];
      a[3] = s_ff[3];
      a[4] = s_ff[4] ^ s_ff[3];
      for (int i = 0; i < 5; i++)
         b[i] = a[i] ^ (~a[(i+1)%5] & a[(i+2)%5]);
      b[1] = b[1] ^ b[0];
      b[0] = b[0] ^ b[4];
      b[3] = b[3] ^ b[2];
      b[2] = ~b[2];
      c[0] = b[0] ^ {b[0][18:0], b[0][63:19]} ^ {b[0][27:0], b[0][63:28]};
      c[1] = b[1] ^ {b[1][60:0], b[1][63:61]} ^ {b[1][38:0], b[1][63:39]};
      c[2] = b[2] ^ {b[2][0], b[2][63:1]} ^ {b[2][5:0], b[2][63:6]};
      c[3] = b[3] ^ {b[3][9:0], b[3][63:10]} ^ {b[3][16:0], b[3][63:17]};
      c[4] = b[4] ^ {b[4][6:0], b[4][63:7]} ^ {b[4][40:0], b[4][63:41]};
   end

   always_comb begin
      for (int i = 0; i < 5; i++) s_in[i] = s_ff[i];
      o_high_in = o_high_ff;
      o_low_in  = o_low_ff;
      match_in  = match_ff;
      x0 = s_ff[0] ^ (data_high & m0);
      x1 = s_ff[1] ^ (data_low & m1);
      t0 = s_ff[3] ^ key_high;
      t1 = s_ff[4] ^ key_low;
      case (ctrl.cmd)
         CMD_LOAD: begin
            s_in[0] = pq ? {IV_80PQ, key_top} : (wide ? IV_128A : IV_128);
            s_in[1] = key_high;
            s_in[2] = key_low;
            s_in[3] = nonce_high;
            s_in[4] = nonce_low;
         end
         CMD_ROUND: for (int i = 0; i < 5; i++) s_in[i] = c[i];
         CMD_KEYIN: begin
            if (pq) s_in[2] = s_ff[2] ^ {32'd0, key_top};
            s_in[3] = s_ff[3] ^ key_high;
            s_in[4] = s_ff[4] ^ key_low;
         end
         CMD_ABS: begin
            s_in[0] = x0 ^ (ctrl.pad_n ? pad0 : 64'd0);
            s_in[1] = (wide ? x1 : s_ff[1]) ^ (ctrl.pad_n ? pad1 : 64'd0);
         end
         CMD_MSG: begin
            o_high_in = (s_ff[0] ^ data_high) & m0;
            o_low_in  = (s_ff[1] ^ data_low) & m1;
            if (direction) begin
               s_in[0] = (s_ff[0] & ~m0) | (data_high & m0);
               s_in[1] = (s_ff[1] & ~m1) | (data_low & m1);
            end else begin
               s_in[0] = x0;
               s_in[1] = x1;
            end
            if (ctrl.pad_n) begin
               s_in[0] = s_in[0] ^ pad0;
               s_in[1] = s_in[1] ^ pad1;
            end
         end
         CMD_PAD0: s_in[0] = s_ff[0] ^ {PAD_BYTE, 56'd0};
         CMD_SEP:  s_in[4] = s_ff[4] ^ 64'd1;
         default: ;
      endcase
      if (ctrl.fin_key) begin
         if (pq) begin
            s_in[1] = s_ff[1] ^ {key_top, key_high[63:32]};
            s_in[2] = s_ff[2] ^ {key_high[31:0], key_low[63:32]};
            s_in[3] = s_ff[3] ^ {key_low[31:0], 32'd0};
         end else if (wide) begin
            s_in[2] = s_ff[2] ^ key_high;
            s_in[3] = s_ff[3] ^ key_low;
         end else begin
            s_in[1] = s_ff[1] ^ key_high;
            s_in[2] = s_ff[2] ^ key_low;
         end
      end
      if (ctrl.capture) begin
         o_high_in = t0;
         o_low_in  = t1;
         match_in  = direction && (t0 == data_high) && (t1 == data_low);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) s_ff[i] <= '0;
      end else begin
         for (int i = 0; i < 5; i++) s_ff[i] <= s_in[i];
      end
      o_high_ff <= o_high_in;
      o_low_ff  <= o_low_in;
      match_ff  <= match_in;
   end

   assign res_high  = o_high_ff;
   assign res_low   = o_low_ff;
   assign res_match = match_ff;
endmodule
`default_nettype wire

/* hw/rtl/ascon_control.sv */
// Ascon sequencer: phase tracking and per-step datapath commands.
`default_nettype none
module ascon_control
   import ascon_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,      // request accepted
   input  wire logic [1:0]  op,
   input  wire logic        last,
   input  wire logic [4:0]  n_bytes,
   input  wire logic        wide,
   output ctrl_type         ctrl,
   output logic             busy,
   output logic             done,       // pulse: result registered
   output logic             done_msg,
   output logic             done_fin,
   output logic             done_err
);
   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_RND   = 4'd2;
   localparam logic [3:0] S_KEYIN = 4'd3;
   localparam logic [3:0] S_PADA  = 4'd4;  // pending AD pad block
   localparam logic [3:0] S_SEP   = 4'd5;
   localparam logic [3:0] S_BLOCK = 4'd6;  // AD absorb or message xor
   localparam logic [3:0] S_PADM  = 4'd7;  // msg pad after full last block
   localparam logic [3:0] S_FPAD  = 4'd8;
   localparam logic [3:0] S_FKEY  = 4'd9;
   localparam logic [3:0] S_TAG   = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   // after-rounds continuation
   localparam logic [2:0] K_KEYIN = 3'd0;
   localparam logic [2:0] K_DONE  = 3'd1;
   localparam logic [2:0] K_SEP   = 3'd2;
   localparam logic [2:0] K_PADM  = 3'd3;
   localparam logic [2:0] K_TAG   = 3'd4;

   localparam logic [2:0] PH_IDLE = 3'd0, PH_READY = 3'd1, PH_AD = 3'd2,
                          PH_AD_END = 3'd3, PH_MSG = 3'd4, PH_MSG_END = 3'd5;

   logic [3:0] state_ff, state_in;
   logic [3:0] rnd_ff, rnd_in;
   logic [2:0] next_ff, next_in;
   logic [2:0] phase_ff, phase_in;
   logic       pend_ff, pend_in;
   logic [1:0] op_ff, op_in;
   logic       last_ff, last_in;
   logic       full_ff, full_in;
   logic       err_ff, err_in;
   logic [3:0] drnd;
   logic       closing;

   assign drnd = wide ? 4'd4 : 4'd6;  // first round index of data run
   assign closing = (phase_ff == PH_READY) || (phase_ff == PH_AD_END);

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      next_in  = next_ff;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      op_in    = op_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      err_in   = err_ff;
      ctrl     = '0;
      ctrl.cmd = CMD_NONE;
      ctrl.rnd = rnd_ff;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: if (start) begin
            op_in   = op;
            last_in = last;
            full_in = (n_bytes == (wide ? 5'd16 : 5'd8));
            err_in  = 1'b0;
            case (op)
               OP_START: state_in = S_LOAD;
               OP_AD: begin
                  if (phase_ff == PH_READY || phase_ff == PH_AD) state_in = S_BLOCK;
                  else begin err_in = 1'b1; state_in = S_DONE; end
               end
               OP_MSG: begin
                  if (closing) state_in = pend_ff ? S_PADA : S_SEP;
                  else if (phase_ff == PH_MSG) state_in = S_BLOCK;
                  else begin err_in = 1'b1; state_in = S_DONE; end
               end
               default: begin
                  if (closing) state_in = pend_ff ? S_PADA : S_SEP;
                  else if (phase_ff == PH_MSG_END) state_in = S_FKEY;
                  else begin err_in = 1'b1; state_in = S_DONE; end
               end
            endcase
         end
         S_LOAD: begin
            ctrl.cmd = CMD_LOAD;
            rnd_in   = 4'd0;
            next_in  = K_KEYIN;
            state_in = S_RND;
         end
         S_RND: begin
            ctrl.cmd = CMD_ROUND;
            rnd_in   = rnd_ff + 4'd1;
            if (rnd_ff == 4'd11) begin
               case (next_ff)
                  K_KEYIN: state_in = S_KEYIN;
                  K_SEP:   state_in = S_SEP;
                  K_PADM:  state_in = S_PADM;
                  K_TAG:   state_in = S_TAG;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_KEYIN: begin
            ctrl.cmd = CMD_KEYIN;
            phase_in = PH_READY;
            pend_in  = 1'b0;
            state_in = S_DONE;
         end
         S_PADA: begin
            ctrl.cmd = CMD_PAD0;
            pend_in  = 1'b0;
            rnd_in   = drnd;
            next_in  = K_SEP;
            state_in = S_RND;
         end
         S_SEP: begin
            ctrl.cmd = CMD_SEP;
            if (op_ff == OP_MSG) state_in = S_BLOCK;
            else state_in = S_FPAD;
         end
         S_BLOCK: begin
            rnd_in  = drnd;
            if (op_ff == OP_AD) begin
               ctrl.cmd   = CMD_ABS;
               ctrl.pad_n = last_ff && !full_ff;
               if (last_ff) begin
                  phase_in = PH_AD_END;
                  if (full_ff) pend_in = 1'b1;
               end else phase_in = PH_AD;
               next_in  = K_DONE;
               state_in = S_RND;
            end else begin
               ctrl.cmd   = CMD_MSG;
               ctrl.pad_n = last_ff && !full_ff;
               if (!last_ff) begin
                  phase_in = PH_MSG;
                  next_in  = K_DONE;
                  state_in = S_RND;
               end else begin
                  phase_in = PH_MSG_END;
                  if (full_ff) begin
                     next_in  = K_PADM;
                     state_in = S_RND;
                  end else state_in = S_DONE;
               end
            end
         end
         S_PADM: begin
            ctrl.cmd = CMD_PAD0;
            state_in = S_DONE;
         end
         S_FPAD: begin
            ctrl.cmd = CMD_PAD0;
            state_in = S_FKEY;
         end
         S_FKEY: begin
            ctrl.fin_key = 1'b1;
            rnd_in   = 4'd0;
            next_in  = K_TAG;
            state_in = S_RND;
         end
         S_TAG: begin
            ctrl.capture = 1'b1;
            phase_in = PH_IDLE;
            pend_in  = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy     = (state_ff != S_IDLE);
   assign done_msg = (op_ff == OP_MSG) && !err_ff;
   assign done_fin = (op_ff == OP_FIN) && !err_ff;
   assign done_err = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         pend_ff  <= 1'b0;
         err_ff   <= 1'b0;
         op_ff    <= OP_START;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
         op_ff    <= op_in;
      end
      rnd_ff  <= rnd_in;
      next_ff <= next_in;
      last_ff <= last_in;
      full_ff <= full_in;
   end
endmodule
`default_nettype wire

/* hw/rtl/ascon_aead_engine.sv */
// Ascon AEAD engine top level: CSR port, request/response handshake.
`default_nettype none
// Ascon-128/128a/80pq AEAD engine. One request at a time; the sponge
// permutation runs one round per cycle. A start request runs load, 12
// rounds, key xor and a done step; an AD block an absorb step and 6 or 8
// rounds. A message block runs the same rounds, but the last one runs none
// when partial and adds a padding step when full; a separator step comes
// first when it opens the message run, and a pad step with 6 or 8 rounds
// before that when a full last AD block left a padding block pending.
// Finalize runs key xor, 12 rounds and tag capture after a message run,
// adds separator and padding steps when it closes the AD part itself, and
// the pending padding block as well. The result sits in an output register
// until taken; once the engine is idle again, the next request is accepted
// no earlier than the cycle in which the result is taken.
module ascon_aead_engine
   import ascon_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [63:0] req_data_high,
   input  wire logic [63:0] req_data_low,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic        req_last_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_out_high,
   output logic [63:0]      rsp_out_low,
   output logic [4:0]       rsp_out_count,
   output logic             rsp_is_tag,
   output logic             rsp_tag_match,
   output logic             rsp_order_error,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   localparam logic [2:0] R_VARIANT = 3'd0, R_DIR = 3'd1, R_KTOP = 3'd2,
      R_KHIGH = 3'd3, R_KLOW = 3'd4, R_NHIGH = 3'd5, R_NLOW = 3'd6;

   logic [1:0]  variant_ff;
   logic        dir_ff;
   logic [31:0] ktop_ff;
   logic [63:0] khigh_ff, klow_ff, nhigh_ff, nlow_ff;
   logic        wr;
   logic [2:0]  ridx;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[5:3];
   assign wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2:0] == 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= '0; dir_ff <= 1'b0; ktop_ff <= '0;
         khigh_ff <= '0; klow_ff <= '0; nhigh_ff <= '0; nlow_ff <= '0;
      end else if (wr) begin
         case (ridx)
            R_VARIANT: variant_ff <= csr_pwdata[1:0];
            R_DIR:     dir_ff     <= csr_pwdata[0];
            R_KTOP:    ktop_ff    <= csr_pwdata[31:0];
            R_KHIGH:   khigh_ff   <= csr_pwdata;
            R_KLOW:    klow_ff    <= csr_pwdata;
            R_NHIGH:   nhigh_ff   <= csr_pwdata;
            R_NLOW:    nlow_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         R_VARIANT: csr_prdata = {62'd0, variant_ff};
         R_DIR:     csr_prdata = {63'd0, dir_ff};
         R_KTOP:    csr_prdata = {32'd0, ktop_ff};
         R_KHIGH:   csr_prdata = khigh_ff;
         R_KLOW:    csr_prdata = klow_ff;
         R_NHIGH:   csr_prdata = nhigh_ff;
         R_NLOW:    csr_prdata = nlow_ff;
         default:   csr_prdata = '0;
      endcase
   end

   // request capture
   logic        wide, busy, done, d_msg, d_fin, d_err, accept, match;
   logic [63:0] dh_ff, dl_ff, rh, rl;
   logic [4:0]  n_ff, n_now, rate;
   ctrl_type    ctrl;

   assign wide = (variant_ff == VAR_128A);
   assign rate = wide ? 5'd16 : 5'd8;
   assign n_now = req_last_block ? ((req_byte_count > rate) ? rate : req_byte_count) : rate;
   assign req_stall = busy || (rsp_valid && rsp_stall);
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         dh_ff   <= req_data_high;
         dl_ff   <= req_data_low;
         n_ff    <= n_now;
      end
   end

   ascon_control u_ctrl (
      .clock(clock), .reset(reset), .start(accept), .op(req_op),
      .last(req_last_block), .n_bytes(n_now), .wide(wide), .ctrl(ctrl),
      .busy(busy), .done(done), .done_msg(d_msg), .done_fin(d_fin),
      .done_err(d_err)
   );

   ascon_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .variant(variant_ff),
      .direction(dir_ff), .key_top(ktop_ff), .key_high(khigh_ff),
      .key_low(klow_ff), .nonce_high(nhigh_ff), .nonce_low(nlow_ff),
      .data_high(dh_ff), .data_low(dl_ff), .n_bytes(n_ff),
      .res_high(rh), .res_low(rl), .res_match(match)
   );

   // response register
   logic        rv_ff;
   logic [63:0] oh_ff, ol_ff;
   logic [4:0]  oc_ff;
   logic        tag_ff, tm_ff, oe_ff;

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (done) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
      if (done) begin
         oh_ff  <= (d_msg || d_fin) ? rh : 64'd0;
         ol_ff  <= (d_msg || d_fin) ? rl : 64'd0;
         oc_ff  <= d_fin ? 5'd16 : (d_msg ? n_ff : 5'd0);
         tag_ff <= d_fin;
         tm_ff  <= d_fin && match;
         oe_ff  <= d_err;
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_high    = oh_ff;
   assign rsp_out_low     = ol_ff;
   assign rsp_out_count   = oc_ff;
   assign rsp_is_tag      = tag_ff;
   assign rsp_tag_match   = tm_ff;
   assign rsp_order_error = oe_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept) else $error("request accepted while busy");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy) else $error("done outside a run");
   a_tag_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tag_match |-> rsp_is_tag) else $error("match without tag");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_order_error |-> !rsp_is_tag && rsp_out_count == 5'd0)
      else $error("error response not clean");
`endif
endmodule
`default_nettype wire
